// ----- rtl/nps_pkg.sv -----
`default_nettype none

package nps_pkg;

    localparam int MAX_JOBS = 16;
    localparam int SLOT_W   = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    localparam int ARR_W    = 16;
    localparam int PRIO_W   = 8;
    localparam int BURST_W  = 16;
    localparam int OSLOT_W  = 4;
    localparam int TIME_W   = 21;
    localparam int SUM_W    = 25;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified job record on its way from the front to the scheduler
    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic               last;
        logic               keep;
    } job_rec_t;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_SCAN,
        BK_FIN
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/nps_front.sv -----
`default_nettype none

module nps_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      job_valid,
    output logic                           job_ready,
    input  wire logic [nps_pkg::ARR_W-1:0]   arrival_time,
    input  wire logic [nps_pkg::PRIO_W-1:0]  prio_level,
    input  wire logic [nps_pkg::BURST_W-1:0] burst_length,
    input  wire logic                      last_job,
    output logic                           push,
    output nps_pkg::job_rec_t              push_rec,
    input  wire logic                      push_ready
);
    import nps_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             keep;
    logic             fire;

    assign keep      = (cnt_reg < CNT_W'(MAX_JOBS));
    assign job_ready = push_ready;
    assign fire      = job_valid && push_ready;

    // records past the table size are dropped unless they close the batch
    assign push = job_valid && (keep || last_job);

    always_comb
    begin
        push_rec.arrival = arrival_time;
        push_rec.prio    = prio_level;
        push_rec.burst   = burst_length;
        push_rec.last    = last_job;
        push_rec.keep    = keep;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (fire)
        begin
            if (last_job)
            begin
                cnt_next = '0;
            end
            else if (keep)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nps_queue.sv -----
`default_nettype none

module nps_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire nps_pkg::job_rec_t wr_rec,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output nps_pkg::job_rec_t      rd_rec
);
    import nps_pkg::*;

    // two entries: the head is what the scheduler sees, the tail waits behind it
    job_rec_t          head_reg;
    job_rec_t          tail_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_rec   = head_reg;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr && ((cnt_reg == '0) || ((cnt_reg == QCNT_W'(1)) && do_rd)))
        begin
            head_reg <= wr_rec;
        end
        else if (do_wr)
        begin
            tail_reg <= wr_rec;
        end
        else if (do_rd && (cnt_reg == QCNT_W'(QUEUE_DEPTH)))
        begin
            head_reg <= tail_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/nps_sched.sv -----
`default_nettype none

module nps_sched (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire nps_pkg::job_rec_t            q_rec,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [nps_pkg::OSLOT_W-1:0]       job_slot,
    output logic [nps_pkg::TIME_W-1:0]        wait_ticks,
    output logic [nps_pkg::TIME_W-1:0]        finish_tick,
    output logic [nps_pkg::TIME_W-1:0]        turnaround_ticks,
    output logic [nps_pkg::SUM_W-1:0]         sum_wait,
    output logic [nps_pkg::SUM_W-1:0]         sum_turnaround,
    output logic                              run_end
);
    import nps_pkg::*;

    // job table
    logic [ARR_W-1:0]   arr_tab   [MAX_JOBS];
    logic [PRIO_W-1:0]  prio_tab  [MAX_JOBS];
    logic [BURST_W-1:0] burst_tab [MAX_JOBS];

    back_state_t state_reg;
    back_state_t state_next;

    logic [MAX_JOBS-1:0] done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    ran_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [SUM_W-1:0]    wtot_reg;
    logic [SUM_W-1:0]    ttot_reg;

    // registered table read and the slot it belongs to
    logic                cmp_valid_reg;
    logic [SLOT_W-1:0]   cmp_idx_reg;
    logic [ARR_W-1:0]    rd_arr_reg;
    logic [PRIO_W-1:0]   rd_prio_reg;
    logic [BURST_W-1:0]  rd_burst_reg;

    // best ready candidate so far
    logic                rdy_found_reg;
    logic [SLOT_W-1:0]   rdy_slot_reg;
    logic [ARR_W-1:0]    rdy_arr_reg;
    logic [PRIO_W-1:0]   rdy_prio_reg;
    logic [BURST_W-1:0]  rdy_burst_reg;

    // earliest pending candidate, the pick when nothing is ready yet
    logic                ear_found_reg;
    logic [SLOT_W-1:0]   ear_slot_reg;
    logic [ARR_W-1:0]    ear_arr_reg;
    logic [PRIO_W-1:0]   ear_prio_reg;
    logic [BURST_W-1:0]  ear_burst_reg;

    logic                res_valid_reg;
    logic [OSLOT_W-1:0]  slot_out_reg;
    logic [TIME_W-1:0]   wait_out_reg;
    logic [TIME_W-1:0]   fin_out_reg;
    logic [TIME_W-1:0]   tat_out_reg;
    logic [SUM_W-1:0]    swait_out_reg;
    logic [SUM_W-1:0]    stat_out_reg;
    logic                end_out_reg;

    logic                pop;
    logic                scan_last;
    logic [ARR_W-1:0]    cur_arr;
    logic [PRIO_W-1:0]   cur_prio;
    logic [BURST_W-1:0]  cur_burst;
    logic                cur_pend;
    logic                cur_ready;
    logic                rdy_better;
    logic                ear_better;
    logic                commit;
    logic                run_done;
    logic [TIME_W-1:0]   start_t;
    logic [SLOT_W-1:0]   sel_slot;
    logic [ARR_W-1:0]    sel_arr;
    logic [BURST_W-1:0]  sel_burst;
    logic [TIME_W-1:0]   wait_t;
    logic [TIME_W-1:0]   fin_t;
    logic [TIME_W-1:0]   tat_t;
    logic [SUM_W-1:0]    wtot_new;
    logic [SUM_W-1:0]    ttot_new;

    assign pop       = (state_reg == BK_LOAD) && q_valid;
    assign q_ready   = (state_reg == BK_LOAD);
    assign scan_last = (idx_reg == SLOT_W'(cnt_reg - CNT_W'(1)));

    assign cur_arr   = rd_arr_reg;
    assign cur_prio  = rd_prio_reg;
    assign cur_burst = rd_burst_reg;
    assign cur_pend  = !done_reg[cmp_idx_reg];
    assign cur_ready = cur_pend && (TIME_W'(cur_arr) <= now_reg);

    assign rdy_better = cur_ready && (!rdy_found_reg || (cur_prio < rdy_prio_reg) ||
                        ((cur_prio == rdy_prio_reg) && (cur_arr < rdy_arr_reg)));
    assign ear_better = cur_pend && (!ear_found_reg || (cur_arr < ear_arr_reg) ||
                        ((cur_arr == ear_arr_reg) && (cur_prio < ear_prio_reg)));

    // nothing ready: time jumps to the earliest arrival
    assign start_t   = rdy_found_reg ? now_reg : TIME_W'(ear_arr_reg);
    assign sel_slot  = rdy_found_reg ? rdy_slot_reg : ear_slot_reg;
    assign sel_arr   = rdy_found_reg ? rdy_arr_reg : ear_arr_reg;
    assign sel_burst = rdy_found_reg ? rdy_burst_reg : ear_burst_reg;
    assign wait_t    = start_t - TIME_W'(sel_arr);
    assign fin_t     = start_t + TIME_W'(sel_burst);
    assign tat_t     = fin_t - TIME_W'(sel_arr);
    assign wtot_new  = wtot_reg + SUM_W'(wait_t);
    assign ttot_new  = ttot_reg + SUM_W'(tat_t);

    // the last slot read is compared in the first finish cycle
    assign commit    = (state_reg == BK_FIN) && !cmp_valid_reg &&
                       (!res_valid_reg || res_ready);
    assign run_done  = ((ran_reg + CNT_W'(1)) == cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_LOAD:
            begin
                if (pop && q_rec.last)
                begin
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                if (commit)
                begin
                    state_next = run_done ? BK_LOAD : BK_SCAN;
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_rec.keep)
        begin
            arr_tab[cnt_reg[SLOT_W-1:0]]   <= q_rec.arrival;
            prio_tab[cnt_reg[SLOT_W-1:0]]  <= q_rec.prio;
            burst_tab[cnt_reg[SLOT_W-1:0]] <= q_rec.burst;
        end
        if (state_reg == BK_SCAN)
        begin
            rd_arr_reg   <= arr_tab[idx_reg];
            rd_prio_reg  <= prio_tab[idx_reg];
            rd_burst_reg <= burst_tab[idx_reg];
            cmp_idx_reg  <= idx_reg;
        end
        if (cmp_valid_reg && rdy_better)
        begin
            rdy_slot_reg  <= cmp_idx_reg;
            rdy_arr_reg   <= cur_arr;
            rdy_prio_reg  <= cur_prio;
            rdy_burst_reg <= cur_burst;
        end
        if (cmp_valid_reg && ear_better)
        begin
            ear_slot_reg  <= cmp_idx_reg;
            ear_arr_reg   <= cur_arr;
            ear_prio_reg  <= cur_prio;
            ear_burst_reg <= cur_burst;
        end
        if (commit)
        begin
            slot_out_reg  <= OSLOT_W'(sel_slot);
            wait_out_reg  <= wait_t;
            fin_out_reg   <= fin_t;
            tat_out_reg   <= tat_t;
            swait_out_reg <= wtot_new;
            stat_out_reg  <= ttot_new;
            end_out_reg   <= run_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            cnt_reg       <= '0;
            ran_reg       <= '0;
            idx_reg       <= '0;
            now_reg       <= '0;
            wtot_reg      <= '0;
            ttot_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            rdy_found_reg <= 1'b0;
            ear_found_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= (state_reg == BK_SCAN);

            if (pop && q_rec.keep)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (state_reg == BK_SCAN)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end

            if (cmp_valid_reg)
            begin
                if (rdy_better)
                begin
                    rdy_found_reg <= 1'b1;
                end
                if (ear_better)
                begin
                    ear_found_reg <= 1'b1;
                end
            end

            if (commit)
            begin
                res_valid_reg <= 1'b1;
                idx_reg       <= '0;
                rdy_found_reg <= 1'b0;
                ear_found_reg <= 1'b0;
                if (run_done)
                begin
                    done_reg <= '0;
                    cnt_reg  <= '0;
                    ran_reg  <= '0;
                    now_reg  <= '0;
                    wtot_reg <= '0;
                    ttot_reg <= '0;
                end
                else
                begin
                    done_reg[sel_slot] <= 1'b1;
                    ran_reg            <= ran_reg + CNT_W'(1);
                    now_reg            <= fin_t;
                    wtot_reg           <= wtot_new;
                    ttot_reg           <= ttot_new;
                end
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid        = res_valid_reg;
    assign job_slot         = slot_out_reg;
    assign wait_ticks       = wait_out_reg;
    assign finish_tick      = fin_out_reg;
    assign turnaround_ticks = tat_out_reg;
    assign sum_wait         = swait_out_reg;
    assign sum_turnaround   = stat_out_reg;
    assign run_end          = end_out_reg;

endmodule

`default_nettype wire

// ----- rtl/nonpreemptive_priority_scheduler.sv -----
// channel   handshake              payload
// job       job_valid/job_ready    arrival_time, prio_level, burst_length, last_job
// result    res_valid/res_ready    job_slot, wait_ticks, finish_tick, turnaround_ticks,
//                                  sum_wait, sum_turnaround, run_end
//
// job records are taken one per cycle while the queue has room, into a two-entry queue, and
// loaded into the table from it; records past MAX_JOBS are dropped. a run over n jobs scans
// all n loaded slots once per job, one slot per cycle, through a registered table read.
// records of the next batch enter the queue while a run is busy, until it fills. reset is
// asynchronous and leaves the block empty and ready; a stalled result holds the scheduler
// in its commit step.
`default_nettype none

module nonpreemptive_priority_scheduler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    output logic                               job_ready,
    input  wire logic [nps_pkg::ARR_W-1:0]     arrival_time,
    input  wire logic [nps_pkg::PRIO_W-1:0]    prio_level,
    input  wire logic [nps_pkg::BURST_W-1:0]   burst_length,
    input  wire logic                          last_job,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [nps_pkg::OSLOT_W-1:0]        job_slot,
    output logic [nps_pkg::TIME_W-1:0]         wait_ticks,
    output logic [nps_pkg::TIME_W-1:0]         finish_tick,
    output logic [nps_pkg::TIME_W-1:0]         turnaround_ticks,
    output logic [nps_pkg::SUM_W-1:0]          sum_wait,
    output logic [nps_pkg::SUM_W-1:0]          sum_turnaround,
    output logic                               run_end
);
    import nps_pkg::*;

    logic     push;
    logic     push_ready;
    job_rec_t push_rec;
    logic     q_valid;
    logic     q_ready;
    job_rec_t q_rec;

    nps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .arrival_time (arrival_time),
        .prio_level   (prio_level),
        .burst_length (burst_length),
        .last_job     (last_job),
        .push         (push),
        .push_rec     (push_rec),
        .push_ready   (push_ready)
    );

    nps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_rec   (push_rec),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_rec   (q_rec)
    );

    nps_sched u_sched (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_rec            (q_rec),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .job_slot         (job_slot),
        .wait_ticks       (wait_ticks),
        .finish_tick      (finish_tick),
        .turnaround_ticks (turnaround_ticks),
        .sum_wait         (sum_wait),
        .sum_turnaround   (sum_turnaround),
        .run_end          (run_end)
    );

endmodule

`default_nettype wire
